// ===== hdl/bfsa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfsa_pkg
// Types and constants shared by the best-fit segment allocator.
// ----------------------------------------------------------------------------
package bfsa_pkg;

    localparam int ADDR_W = 16;
    localparam int SIZE_W = 17;

    localparam logic [SIZE_W-1:0] POOL_RESET = 17'd40960;
    localparam logic [SIZE_W-1:0] POOL_LIMIT = 17'd65536;

    localparam logic       CMD_ALLOC = 1'b0;
    localparam logic       CMD_FREE  = 1'b1;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_ZERO    = 2'd1;
    localparam logic [1:0] STAT_NOFIT   = 2'd2;
    localparam logic [1:0] STAT_BADFREE = 2'd3;

    localparam logic       REG_POOL_SIZE = 1'b0;

    typedef struct packed {
        logic              free;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] start;
    } t_seg;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_MOVE,
        S_WTAIL,
        S_WHEAD,
        S_FNEXT,
        S_FGETN,
        S_FMERGE,
        S_FWRITE,
        S_RESP
    } t_state;

endpackage

// ===== hdl/bfsa_if.sv =====
// ----------------------------------------------------------------------------
// bfsa_if
// Request and response channels of the segment allocator.
// ----------------------------------------------------------------------------
interface bfsa_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [15:0] req_size;
    logic [15:0] free_addr;

    modport source (output valid, output cmd, output req_size, output free_addr,
                    input ready);
    modport sink   (input valid, input cmd, input req_size, input free_addr,
                    output ready);
endinterface

interface bfsa_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] alloc_addr;

    modport source (output valid, output status, output alloc_addr, input ready);
    modport sink   (input valid, input status, input alloc_addr, output ready);
endinterface

// ===== hdl/bfsa_seg_ram.sv =====
// ----------------------------------------------------------------------------
// bfsa_seg_ram
// Segment table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bfsa_seg_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  bfsa_pkg::t_seg i_wdata,
    input  logic [AW-1:0] i_raddr,
    output bfsa_pkg::t_seg o_rdata
);

    bfsa_pkg::t_seg r_mem [DEPTH];
    bfsa_pkg::t_seg r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/best_fit_segment_allocator_core.sv =====
// ----------------------------------------------------------------------------
// best_fit_segment_allocator_core
// Best-fit allocator over an address-ordered segment table, with split on
// allocate and merge with free neighbors on release.
//
//   port      dir  kind         payload
//   i_req     in   valid/ready  cmd, req_size, free_addr
//   o_rsp     out  valid/ready  status, alloc_addr
//   APB       in   psel/penable pool_size at address 0
//
// One request at a time. An allocate scans the table and, on a split,
// moves the upper entries up one slot, then writes the tail and head
// entries; a free scans, reads its upper neighbor, merges, then removes
// merged entries the same way, all paced by the single table read port.
// Reset and a pool_size write rebuild entry 0 in the S_INIT state.
// A finished response waits in the output register while o_rsp stalls.
// ----------------------------------------------------------------------------
module best_fit_segment_allocator_core #(
    parameter int MAX_SEGMENTS = 64,
    parameter int HEADER_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bfsa_req_if.sink    i_req,
    bfsa_rsp_if.source  o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int SW = bfsa_pkg::SIZE_W;
    localparam int DW = bfsa_pkg::ADDR_W;
    localparam logic [SW-1:0] HDR   = SW'(HEADER_BYTES);
    localparam logic [CW-1:0] C_MAX = CW'(MAX_SEGMENTS);
    localparam logic [CW-1:0] C_ONE = CW'(1);

    bfsa_pkg::t_state r_state, n_state, r_after;

    logic [SW-1:0] r_pool;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_idx;
    logic          r_qv;
    logic [AW-1:0] r_qidx;
    logic          r_cmd;
    logic [15:0]   r_req;
    logic [15:0]   r_where;
    logic          r_found;
    logic [AW-1:0] r_pick;
    bfsa_pkg::t_seg r_best;
    bfsa_pkg::t_seg r_prev;
    logic          r_nv;
    logic          r_nxt;
    logic          r_prv;
    logic [SW-1:0] r_acc;
    logic [AW-1:0] r_mv_src;
    logic [CW-1:0] r_mv_left;
    logic          r_mv_up;
    logic [1:0]    r_mv_dist;
    logic [1:0]    r_status;
    logic [15:0]   r_addr;
    logic          r_ovld;
    logic [1:0]    r_ost;
    logic [15:0]   r_oaddr;

    bfsa_pkg::t_seg q;
    logic          we;
    logic [AW-1:0] waddr;
    bfsa_pkg::t_seg wdata;
    logic [AW-1:0] raddr;

    logic          cfg_wr;
    logic          req_xfer;
    logic          rsp_load;
    logic [SW-1:0] init_size;
    logic [SW-1:0] cfg_val;
    logic          cand;
    logic          hit;
    logic          scan_stop;
    logic          scan_issue;
    logic          scan_done;
    logic          mv_issue;
    logic          mv_done;
    logic          split;
    logic          prv_c;
    logic [1:0]    k_rm;
    logic [CW-1:0] first_rm;
    logic [CW-1:0] pick_w;

    bfsa_seg_ram #(.DEPTH(MAX_SEGMENTS), .AW(AW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (q)
    );

    assign pready   = 1'b1;
    assign prdata   = 32'(r_pool);
    assign cfg_wr   = psel && penable && pwrite && (paddr == bfsa_pkg::REG_POOL_SIZE);
    assign cfg_val  = (pwdata[SW-1:0] > bfsa_pkg::POOL_LIMIT) ? bfsa_pkg::POOL_LIMIT
                                                               : pwdata[SW-1:0];
    assign init_size = (r_pool > HDR) ? r_pool - HDR : '0;

    assign i_req.ready      = (r_state == bfsa_pkg::S_IDLE);
    assign req_xfer         = i_req.valid && i_req.ready;
    assign o_rsp.valid      = r_ovld;
    assign o_rsp.status     = r_ost;
    assign o_rsp.alloc_addr = r_oaddr;
    assign rsp_load         = (r_state == bfsa_pkg::S_RESP) && (!r_ovld || o_rsp.ready);

    assign pick_w = CW'(r_pick);

    // scan evaluation of the entry returned by the read port
    assign cand = q.free && (q.size >= SW'(r_req))
                  && (!r_found || (q.size < r_best.size));
    assign hit  = (({1'b0, q.start} + HDR) == {1'b0, r_where});
    assign scan_stop  = r_qv && ((r_cmd == bfsa_pkg::CMD_ALLOC)
                                 ? (cand && (q.size == SW'(r_req))) : hit);
    assign scan_issue = (r_idx < r_cnt) && !scan_stop;
    assign scan_done  = scan_stop || (!scan_issue && !r_qv);

    assign mv_issue = (r_mv_left != '0);
    assign mv_done  = !mv_issue && !r_qv;

    assign split = (r_best.size > (SW'(r_req) + HDR)) && (r_cnt < C_MAX);

    assign prv_c    = (r_pick != '0) && r_prev.free;
    assign k_rm     = {1'b0, r_nxt} + {1'b0, r_prv};
    assign first_rm = r_prv ? pick_w : pick_w + C_ONE;

    always_comb begin
        n_state = r_state;
        case (r_state)
            bfsa_pkg::S_INIT: n_state = bfsa_pkg::S_IDLE;
            bfsa_pkg::S_IDLE: begin
                if (req_xfer) begin
                    if (i_req.cmd == bfsa_pkg::CMD_ALLOC && i_req.req_size == '0) begin
                        n_state = bfsa_pkg::S_RESP;
                    end else begin
                        n_state = bfsa_pkg::S_SCAN;
                    end
                end
            end
            bfsa_pkg::S_SCAN: begin
                if (scan_done) begin
                    if (r_cmd == bfsa_pkg::CMD_ALLOC) begin
                        n_state = bfsa_pkg::S_DECIDE;
                    end else if (scan_stop && !q.free) begin
                        n_state = bfsa_pkg::S_FNEXT;
                    end else begin
                        n_state = bfsa_pkg::S_RESP;
                    end
                end
            end
            bfsa_pkg::S_DECIDE: begin
                if (r_found && split) begin
                    n_state = bfsa_pkg::S_MOVE;
                end else begin
                    n_state = bfsa_pkg::S_RESP;
                end
            end
            bfsa_pkg::S_MOVE:   if (mv_done) n_state = r_after;
            bfsa_pkg::S_WTAIL:  n_state = bfsa_pkg::S_WHEAD;
            bfsa_pkg::S_WHEAD:  n_state = bfsa_pkg::S_RESP;
            bfsa_pkg::S_FNEXT:  n_state = bfsa_pkg::S_FGETN;
            bfsa_pkg::S_FGETN:  n_state = bfsa_pkg::S_FMERGE;
            bfsa_pkg::S_FMERGE: n_state = bfsa_pkg::S_FWRITE;
            bfsa_pkg::S_FWRITE: begin
                n_state = (k_rm == '0) ? bfsa_pkg::S_RESP : bfsa_pkg::S_MOVE;
            end
            bfsa_pkg::S_RESP:   if (rsp_load) n_state = bfsa_pkg::S_IDLE;
            default:            n_state = bfsa_pkg::S_INIT;
        endcase
        if (cfg_wr) begin
            n_state = bfsa_pkg::S_INIT;
        end
    end

    always_comb begin
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr = '0;
        case (r_state)
            bfsa_pkg::S_INIT: begin
                we    = 1'b1;
                wdata = '{free: 1'b1, size: init_size, start: '0};
            end
            bfsa_pkg::S_SCAN: raddr = r_idx[AW-1:0];
            bfsa_pkg::S_DECIDE: begin
                we    = r_found && !split;
                waddr = r_pick;
                wdata = '{free: 1'b0, size: r_best.size, start: r_best.start};
            end
            bfsa_pkg::S_MOVE: begin
                raddr = r_mv_src;
                we    = r_qv;
                waddr = r_mv_up ? r_qidx + AW'(1) : r_qidx - AW'(r_mv_dist);
                wdata = q;
            end
            bfsa_pkg::S_WTAIL: begin
                we    = 1'b1;
                waddr = r_pick + AW'(1);
                wdata = '{free: 1'b1,
                          size: r_best.size - HDR - SW'(r_req),
                          start: r_best.start + DW'(HEADER_BYTES) + r_req};
            end
            bfsa_pkg::S_WHEAD: begin
                we    = 1'b1;
                waddr = r_pick;
                wdata = '{free: 1'b0, size: SW'(r_req), start: r_best.start};
            end
            bfsa_pkg::S_FNEXT: raddr = r_pick + AW'(1);
            bfsa_pkg::S_FWRITE: begin
                we    = 1'b1;
                waddr = r_prv ? r_pick - AW'(1) : r_pick;
                wdata = '{free: 1'b1, size: r_acc,
                          start: r_prv ? r_prev.start : r_best.start};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bfsa_pkg::S_INIT;
            r_pool  <= bfsa_pkg::POOL_RESET;
            r_cnt   <= C_ONE;
            r_qv    <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                r_pool <= cfg_val;
            end
            case (r_state)
                bfsa_pkg::S_INIT:   r_cnt <= C_ONE;
                bfsa_pkg::S_WHEAD:  r_cnt <= r_cnt + C_ONE;
                bfsa_pkg::S_FWRITE: r_cnt <= r_cnt - CW'(k_rm);
                default: ;
            endcase
            case (r_state)
                bfsa_pkg::S_SCAN: r_qv <= scan_issue;
                bfsa_pkg::S_MOVE: r_qv <= mv_issue;
                default:          r_qv <= 1'b0;
            endcase
            if (rsp_load) begin
                r_ovld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rsp_load) begin
            r_ost   <= r_status;
            r_oaddr <= r_addr;
        end
        case (r_state)
            bfsa_pkg::S_IDLE: begin
                r_cmd   <= i_req.cmd;
                r_req   <= i_req.req_size;
                r_where <= i_req.free_addr;
                r_idx   <= '0;
                r_found <= 1'b0;
                r_addr  <= '0;
                r_status <= (i_req.cmd == bfsa_pkg::CMD_ALLOC && i_req.req_size == '0)
                            ? bfsa_pkg::STAT_ZERO : bfsa_pkg::STAT_OK;
            end
            bfsa_pkg::S_SCAN: begin
                if (scan_issue) begin
                    r_idx  <= r_idx + C_ONE;
                    r_qidx <= r_idx[AW-1:0];
                end
                if (r_qv) begin
                    if (r_cmd == bfsa_pkg::CMD_ALLOC) begin
                        if (cand) begin
                            r_found <= 1'b1;
                            r_pick  <= r_qidx;
                            r_best  <= q;
                        end
                    end else if (hit) begin
                        r_pick <= r_qidx;
                        r_best <= q;
                    end else begin
                        r_prev <= q;
                    end
                end
                if (scan_done && r_cmd == bfsa_pkg::CMD_FREE && !(scan_stop && !q.free)) begin
                    r_status <= bfsa_pkg::STAT_BADFREE;
                end
            end
            bfsa_pkg::S_DECIDE: begin
                if (!r_found) begin
                    r_status <= bfsa_pkg::STAT_NOFIT;
                end else begin
                    r_addr <= r_best.start + DW'(HEADER_BYTES);
                end
                r_mv_src  <= AW'(r_cnt - C_ONE);
                r_mv_left <= r_cnt - C_ONE - pick_w;
                r_mv_up   <= 1'b1;
                r_mv_dist <= 2'd1;
                r_after   <= bfsa_pkg::S_WTAIL;
            end
            bfsa_pkg::S_MOVE: begin
                if (mv_issue) begin
                    r_mv_src  <= r_mv_up ? r_mv_src - AW'(1) : r_mv_src + AW'(1);
                    r_mv_left <= r_mv_left - C_ONE;
                    r_qidx    <= r_mv_src;
                end
            end
            bfsa_pkg::S_FNEXT: r_nv <= (pick_w + C_ONE) < r_cnt;
            bfsa_pkg::S_FGETN: begin
                r_nxt <= r_nv && q.free;
                r_acc <= (r_nv && q.free) ? r_best.size + HDR + q.size : r_best.size;
            end
            bfsa_pkg::S_FMERGE: begin
                r_prv <= prv_c;
                if (prv_c) begin
                    r_acc <= r_acc + HDR + r_prev.size;
                end
            end
            bfsa_pkg::S_FWRITE: begin
                r_mv_src  <= AW'(first_rm + CW'(k_rm));
                r_mv_left <= r_cnt - first_rm - CW'(k_rm);
                r_mv_up   <= 1'b0;
                r_mv_dist <= k_rm;
                r_after   <= bfsa_pkg::S_RESP;
            end
            default: ;
        endcase
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != bfsa_pkg::S_INIT) |-> (r_cnt != '0 && r_cnt <= C_MAX))
        else $error("segment count out of range");

    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != bfsa_pkg::STAT_OK) |-> (o_rsp.alloc_addr == '0))
        else $error("address on failed request");

    a_rsp_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovld) |-> ($past(r_state) == bfsa_pkg::S_RESP))
        else $error("response loaded outside response state");

endmodule

// ===== dv/tb_best_fit_segment_allocator_core.sv =====
// ----------------------------------------------------------------------------
// tb_best_fit_segment_allocator_core
// Self-checking bench for the best-fit segment allocator. A behavioral copy
// of the segment table predicts every response, which is compared in order.
// Random traffic runs through several pool sizes and three flow-control
// phases.
// ----------------------------------------------------------------------------
module tb_best_fit_segment_allocator_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSEG = 64;
    localparam int HDR  = 32;

    typedef struct packed {
        logic        cmd;
        logic [15:0] req_size;
        logic [15:0] free_addr;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] alloc_addr;
    } t_rsp;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite, paddr, pready;
    logic [31:0] pwdata, prdata;

    bfsa_req_if req_ch ();
    bfsa_rsp_if rsp_ch ();

    best_fit_segment_allocator_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predicted table
    int unsigned m_start [NSEG];
    int unsigned m_size [NSEG];
    bit          m_free [NSEG];
    int unsigned m_count;
    int unsigned m_pool;

    t_req pending_reqs[$];
    t_rsp expected_rsps[$];
    int unsigned live_addrs[$];
    int   errors;
    int   send_idle_pct;
    int   recv_idle_pct;
    bit   hold_send;

    function automatic void table_init();
        m_start[0] = 0;
        m_size[0]  = (m_pool > HDR) ? m_pool - HDR : 0;
        m_free[0]  = 1'b1;
        m_count    = 1;
    endfunction

    function automatic void drop_seg(int unsigned k);
        for (int unsigned i = k; i + 1 < m_count; i++) begin
            m_start[i] = m_start[i+1];
            m_size[i]  = m_size[i+1];
            m_free[i]  = m_free[i+1];
        end
        m_count--;
    endfunction

    function automatic t_rsp predict_rsp(t_req r);
        t_rsp o;
        int unsigned pick, i;
        bit found;
        o.status = bfsa_pkg::STAT_OK;
        o.alloc_addr = '0;
        pick = 0;
        found = 0;
        if (r.cmd == bfsa_pkg::CMD_ALLOC) begin
            if (r.req_size == 0) begin
                o.status = bfsa_pkg::STAT_ZERO;
                return o;
            end
            for (i = 0; i < m_count; i++) begin
                if (m_free[i] && m_size[i] >= r.req_size &&
                    (!found || m_size[i] < m_size[pick])) begin
                    pick = i;
                    found = 1;
                    if (m_size[i] == r.req_size) break;
                end
            end
            if (!found) begin
                o.status = bfsa_pkg::STAT_NOFIT;
                return o;
            end
            if (m_size[pick] > r.req_size + HDR && m_count < NSEG) begin
                for (i = m_count; i > pick + 1; i--) begin
                    m_start[i] = m_start[i-1];
                    m_size[i]  = m_size[i-1];
                    m_free[i]  = m_free[i-1];
                end
                m_start[pick+1] = m_start[pick] + HDR + r.req_size;
                m_size[pick+1]  = m_size[pick] - HDR - r.req_size;
                m_free[pick+1]  = 1'b1;
                m_count++;
                m_size[pick] = r.req_size;
            end
            m_free[pick] = 1'b0;
            o.alloc_addr = 16'(m_start[pick] + HDR);
        end else begin
            for (i = 0; i < m_count; i++)
                if (m_start[i] + HDR == r.free_addr) break;
            if (i >= m_count || m_free[i]) begin
                o.status = bfsa_pkg::STAT_BADFREE;
                return o;
            end
            m_free[i] = 1'b1;
            if (i + 1 < m_count && m_free[i+1]) begin
                m_size[i] += HDR + m_size[i+1];
                drop_seg(i + 1);
            end
            if (i > 0 && m_free[i-1]) begin
                m_size[i-1] += HDR + m_size[i];
                drop_seg(i);
            end
        end
        return o;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (pending_reqs.size() != 0 && !hold_send &&
                $urandom_range(99) >= send_idle_pct) begin
                t_req r;
                r = pending_reqs.pop_front();
                req_ch.valid     <= 1'b1;
                req_ch.cmd       <= r.cmd;
                req_ch.req_size  <= r.req_size;
                req_ch.free_addr <= r.free_addr;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Predict on accepted request, check on accepted response
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready)
                expected_rsps.push_back(predict_rsp({req_ch.cmd, req_ch.req_size,
                                                     req_ch.free_addr}));
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_rsps.size() == 0) begin
                    $error("unexpected response transfer");
                    errors++;
                end else begin
                    t_rsp e;
                    e = expected_rsps.pop_front();
                    if (rsp_ch.status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, rsp_ch.status);
                        errors++;
                    end
                    if (rsp_ch.alloc_addr !== e.alloc_addr) begin
                        $error("alloc_addr exp %0h got %0h", e.alloc_addr,
                               rsp_ch.alloc_addr);
                        errors++;
                    end
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic apb_write(logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= bfsa_pkg::REG_POOL_SIZE; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        m_pool = (val[16:0] > 65536) ? 65536 : val[16:0];
        table_init();
        repeat (4) @(posedge i_clk);
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // Mostly well-formed traffic: allocs of 1 to maxreq bytes, frees of live addrs
    task automatic add_random(int n, int unsigned maxreq);
        t_req r;
        int unsigned k;
        repeat (n) begin
            r.req_size  = 16'($urandom);
            r.free_addr = 16'($urandom);
            case ($urandom_range(9))
                0, 1, 2, 3: begin
                    r.cmd = bfsa_pkg::CMD_ALLOC;
                    r.req_size = 16'($urandom_range(maxreq, 1));
                    live_addrs.push_back(0);
                end
                4, 5, 6, 7: begin
                    r.cmd = bfsa_pkg::CMD_FREE;
                    k = 0;
                    if (live_addrs.size() != 0) begin
                        k = $urandom_range(live_addrs.size() - 1);
                        r.free_addr = 16'(live_addrs[k]);
                    end
                end
                8: r.cmd = bfsa_pkg::CMD_ALLOC;
                default: r.cmd = bfsa_pkg::CMD_FREE;
            endcase
            pending_reqs.push_back(r);
        end
    endtask

    // Track granted addresses for later frees
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready &&
            rsp_ch.status == bfsa_pkg::STAT_OK && rsp_ch.alloc_addr != 0) begin
            if (live_addrs.size() > 200) void'(live_addrs.pop_front());
            live_addrs.push_back(rsp_ch.alloc_addr);
        end
    end

    initial begin
        errors = 0;
        send_idle_pct = 36;
        recv_idle_pct = 69;
        hold_send = 0;
        i_rst_n = 1'b0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        req_ch.valid = 0; req_ch.cmd = 0; req_ch.req_size = 0; req_ch.free_addr = 0;
        rsp_ch.ready = 0;
        m_pool = bfsa_pkg::POOL_RESET;
        table_init();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(posedge i_clk);

        // Directed: zero, exact fit, split, bad frees, merges, extremes
        pending_reqs.push_back({bfsa_pkg::CMD_ALLOC, 16'd0, 16'hFFFF});
        pending_reqs.push_back({bfsa_pkg::CMD_ALLOC, 16'hFFFF, 16'd0});
        pending_reqs.push_back({bfsa_pkg::CMD_ALLOC, 16'd100, 16'd0});
        pending_reqs.push_back({bfsa_pkg::CMD_ALLOC, 16'd200, 16'd0});
        pending_reqs.push_back({bfsa_pkg::CMD_ALLOC, 16'd50, 16'd0});
        pending_reqs.push_back({bfsa_pkg::CMD_FREE, 16'hFFFF, 16'd0});
        pending_reqs.push_back({bfsa_pkg::CMD_FREE, 16'd0, 16'hFFFF});
        pending_reqs.push_back({bfsa_pkg::CMD_FREE, 16'd0, 16'd32});
        pending_reqs.push_back({bfsa_pkg::CMD_FREE, 16'd0, 16'd32});
        pending_reqs.push_back({bfsa_pkg::CMD_ALLOC, 16'd100, 16'd0});
        pending_reqs.push_back({bfsa_pkg::CMD_FREE, 16'd0, 16'd164});
        pending_reqs.push_back({bfsa_pkg::CMD_FREE, 16'd0, 16'd396});
        pending_reqs.push_back({bfsa_pkg::CMD_FREE, 16'd0, 16'd32});
        pending_reqs.push_back({bfsa_pkg::CMD_ALLOC, 16'd40928, 16'd0});
        pending_reqs.push_back({bfsa_pkg::CMD_FREE, 16'd0, 16'd32});
        drain();

        // Full table: many tiny allocs
        apb_write(32'd4096);
        repeat (70) pending_reqs.push_back({bfsa_pkg::CMD_ALLOC, 16'd1, 16'd0});
        drain();

        apb_write(32'h1FFFF);
        pending_reqs.push_back({bfsa_pkg::CMD_ALLOC, 16'd65504, 16'd0});
        pending_reqs.push_back({bfsa_pkg::CMD_FREE, 16'd0, 16'd32});
        pending_reqs.push_back({bfsa_pkg::CMD_ALLOC, 16'hFFFF, 16'd0});
        drain();

        apb_write(32'd16);
        pending_reqs.push_back({bfsa_pkg::CMD_ALLOC, 16'd1, 16'd0});
        drain();

        apb_write(32'd64);
        add_random(60, 40);
        drain();

        // Pause sender until all responses are in
        add_random(20, 20);
        repeat (30) @(posedge i_clk);
        hold_send = 1;
        while (req_ch.valid || expected_rsps.size() != 0)
            @(posedge i_clk);
        hold_send = 0;
        drain();

        apb_write(32'd2048);
        add_random(300, 120);
        drain();

        send_idle_pct = 69;
        recv_idle_pct = 36;
        apb_write(32'd65536);
        add_random(300, 3000);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        apb_write(32'd40960);
        add_random(300, 1500);
        drain();

        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #4ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
